// ----- hdl/csf_pkg.sv -----
package csf_pkg;

  localparam int PIX_W        = 8;
  localparam int DIM_W        = 10;
  localparam int CNT_W        = 2 * DIM_W;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;
  localparam int MIN_DIM      = 3;
  localparam int RESET_DIM    = 512;
  localparam int SHARPEN_GAIN = 5;
  localparam int PIX_MAX      = 255;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    dim_t width;
    cnt_t total_m1;
    cnt_t total_mw;
  } frame_cfg_t;

  typedef struct packed {
    logic started;
    logic border;
    logic frame_end;
    dim_t cp;
  } step_info_t;

endpackage

// ----- hdl/csf_stream_if.sv -----
interface csf_pix_if;
  import csf_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel_in;
  logic flush;

  modport source (output valid, pixel_in, flush, input ready);
  modport sink (input valid, pixel_in, flush, output ready);
endinterface

interface csf_res_if;
  import csf_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel_out;
  logic frame_end;

  modport source (output valid, pixel_out, frame_end, input ready);
  modport sink (input valid, pixel_out, frame_end, output ready);
endinterface

// ----- hdl/cross_kernel_sharpen_filter.sv -----
// Stage one takes the line-store reads and step info of the input transaction that completes
// a window; the result then goes to the output register. The window trails the input by one
// line plus one pixel. Throughput: one pixel per cycle while the output is not stalled, set by
// the read-modify-write of the line stores. Reset clears the counters, the left and center
// window pixels and the pipeline valids; the line stores keep their contents and need no clearing.
module cross_kernel_sharpen_filter #(
  parameter int MAX_LINE = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csf_pkg::APB_AW-1:0]  paddr,
  input  logic [csf_pkg::APB_DW-1:0]  pwdata,
  output logic [csf_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  csf_pix_if.sink                     pix,
  csf_res_if.source                   res
);
  import csf_pkg::*;

  frame_cfg_t cfg;
  step_info_t info;
  dim_t       ci;
  pix_t       wr_pix;
  pix_t       right;
  pix_t       down;
  pix_t       up;
  logic       fire;
  logic       can_take;
  logic       up_we;
  dim_t       up_addr;
  pix_t       up_data;

  assign fire      = pix.valid && pix.ready;
  assign pix.ready = can_take;
  assign wr_pix    = pix.flush ? '0 : pix.pixel_in;

  csf_cfg_regs #(.MAX_LINE(MAX_LINE)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csf_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cfg  (cfg),
    .ci   (ci),
    .info (info)
  );

  csf_line_mem #(.MAX_LINE(MAX_LINE)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rd_col  (ci),
    .rd_prev (info.cp),
    .wr_pix  (wr_pix),
    .up_we   (up_we),
    .up_addr (up_addr),
    .up_data (up_data),
    .right   (right),
    .down    (down),
    .up      (up)
  );

  csf_sharpen u_sharpen (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .info      (info),
    .right     (right),
    .down      (down),
    .up        (up),
    .can_take  (can_take),
    .up_we     (up_we),
    .up_addr   (up_addr),
    .up_data   (up_data),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_pix   (res.pixel_out),
    .out_end   (res.frame_end)
  );

endmodule

// ----- hdl/csf_cfg_regs.sv -----
module csf_cfg_regs #(
  parameter int MAX_LINE = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csf_pkg::APB_AW-1:0]  paddr,
  input  logic [csf_pkg::APB_DW-1:0]  pwdata,
  output logic [csf_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output csf_pkg::frame_cfg_t         cfg
);
  import csf_pkg::*;

  localparam int   DIM_MAX   = (1 << DIM_W) - 1;
  localparam int   WMAX      = (MAX_LINE > DIM_MAX) ? DIM_MAX : MAX_LINE;
  localparam int   RST_W     = (RESET_DIM > WMAX) ? WMAX : RESET_DIM;
  localparam int   RST_TOTAL = RST_W * RESET_DIM;
  localparam dim_t WMAX_D    = dim_t'(WMAX);
  localparam dim_t MIN_D     = dim_t'(MIN_DIM);

  dim_t     width_raw;
  dim_t     height_raw;
  dim_t     width_next;
  dim_t     height_next;
  dim_t     eff_w;
  dim_t     eff_h;
  cnt_t     total_next;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[APB_AW-1]);

  always_comb begin
    width_next  = width_raw;
    height_next = height_raw;
    if (wr_en && idx == REG_WIDTH) begin
      width_next = pwdata[DIM_W-1:0];
    end
    if (wr_en && idx == REG_HEIGHT) begin
      height_next = pwdata[DIM_W-1:0];
    end
    if (width_next < MIN_D) begin
      eff_w = MIN_D;
    end else if (width_next > WMAX_D) begin
      eff_w = WMAX_D;
    end else begin
      eff_w = width_next;
    end
    eff_h      = (height_next < MIN_D) ? MIN_D : height_next;
    total_next = CNT_W'(eff_w) * CNT_W'(eff_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_raw    <= dim_t'(RESET_DIM);
      height_raw   <= dim_t'(RESET_DIM);
      cfg.width    <= dim_t'(RST_W);
      cfg.total_m1 <= cnt_t'(RST_TOTAL - 1);
      cfg.total_mw <= cnt_t'(RST_TOTAL - RST_W);
    end else begin
      width_raw    <= width_next;
      height_raw   <= height_next;
      cfg.width    <= eff_w;
      cfg.total_m1 <= total_next - 1'b1;
      cfg.total_mw <= total_next - CNT_W'(eff_w);
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = APB_DW'(width_raw);
      REG_HEIGHT: prdata = APB_DW'(height_raw);
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- hdl/csf_line_mem.sv -----
module csf_line_mem #(
  parameter int MAX_LINE = 512
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  csf_pkg::dim_t  rd_col,
  input  csf_pkg::dim_t  rd_prev,
  input  csf_pkg::pix_t  wr_pix,
  input  logic           up_we,
  input  csf_pkg::dim_t  up_addr,
  input  csf_pkg::pix_t  up_data,
  output csf_pkg::pix_t  right,
  output csf_pkg::pix_t  down,
  output csf_pkg::pix_t  up
);
  import csf_pkg::*;

  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

  pix_t          middle_mem [MAX_LINE];
  pix_t          upper_mem  [MAX_LINE];
  logic [AW-1:0] col_a;
  logic [AW-1:0] prev_a;
  logic [AW-1:0] up_a;
  pix_t          up_rd;
  pix_t          fwd_data;
  logic          fwd_hit;

  assign col_a  = AW'(rd_col);
  assign prev_a = AW'(rd_prev);
  assign up_a   = AW'(up_addr);

  always_ff @(posedge clk) begin
    if (fire) begin
      middle_mem[col_a] <= wr_pix;
      right             <= middle_mem[col_a];
      down              <= middle_mem[prev_a];
    end
  end

  always_ff @(posedge clk) begin
    if (up_we) begin
      upper_mem[up_a] <= up_data;
    end
    if (fire) begin
      up_rd <= upper_mem[prev_a];
    end
  end

  // bypass a write that lands on the entry read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (fire) begin
      fwd_hit <= up_we && (up_a == prev_a);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fwd_data <= up_data;
    end
  end

  assign up = fwd_hit ? fwd_data : up_rd;

endmodule

// ----- hdl/csf_ctrl.sv -----
module csf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  csf_pkg::frame_cfg_t  cfg,
  output csf_pkg::dim_t        ci,
  output csf_pkg::step_info_t  info
);
  import csf_pkg::*;

  dim_t       col;
  dim_t       col_next;
  logic [1:0] row;
  logic [1:0] row_next;
  cnt_t       count;
  cnt_t       count_next;

  always_comb begin
    ci       = (col >= cfg.width) ? '0 : col;
    info.cp  = (ci == '0) ? cfg.width - 1'b1 : ci - 1'b1;
    info.started = (row == 2'd2) || (row == 2'd1 && ci != '0);
    info.border  = (count < CNT_W'(cfg.width)) || (count >= cfg.total_mw) ||
                   (info.cp == '0) || (info.cp == cfg.width - 1'b1);
    info.frame_end = info.started && (count >= cfg.total_m1);

    col_next   = ci + 1'b1;
    row_next   = row;
    count_next = count;
    if (col_next >= cfg.width) begin
      col_next = '0;
      if (row != 2'd2) begin
        row_next = row + 1'b1;
      end
    end
    if (info.started) begin
      count_next = count + 1'b1;
    end
    if (info.frame_end) begin
      col_next   = '0;
      row_next   = '0;
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      count <= '0;
    end else if (fire) begin
      col   <= col_next;
      row   <= row_next;
      count <= count_next;
    end
  end

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    fire && info.frame_end |=> col == '0 && row == '0 && count == '0)
    else $error("counters not cleared at end of frame");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    fire && !info.started |-> count == '0)
    else $error("results counted before window filled");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    fire && info.started && !info.frame_end |=> count == $past(count) + 1'b1)
    else $error("result count skipped");

endmodule

// ----- hdl/csf_sharpen.sv -----
module csf_sharpen (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  csf_pkg::step_info_t  info,
  input  csf_pkg::pix_t        right,
  input  csf_pkg::pix_t        down,
  input  csf_pkg::pix_t        up,
  output logic                 can_take,
  output logic                 up_we,
  output csf_pkg::dim_t        up_addr,
  output csf_pkg::pix_t        up_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csf_pkg::pix_t        out_pix,
  output logic                 out_end
);
  import csf_pkg::*;

  localparam int ACC_W = PIX_W + 3;

  logic             s1_valid;
  step_info_t       s1_info;
  pix_t             left;
  pix_t             center;
  logic             adv;
  logic [ACC_W-1:0] five_c;
  logic [ACC_W-1:0] nbr;
  logic [ACC_W-1:0] diff;
  pix_t             res;

  assign adv      = s1_valid && (!s1_info.started || !out_valid || out_ready);
  assign can_take = !s1_valid || adv;
  assign up_we    = adv;
  assign up_addr  = s1_info.cp;
  assign up_data  = center;

  always_comb begin
    five_c = ACC_W'(center) * ACC_W'(SHARPEN_GAIN);
    nbr    = ACC_W'(up) + ACC_W'(down) + ACC_W'(left) + ACC_W'(right);
    diff   = five_c - nbr;
    if (s1_info.border) begin
      res = center;
    end else if (nbr > five_c) begin
      res = '0;
    end else if (diff > ACC_W'(PIX_MAX)) begin
      res = pix_t'(PIX_MAX);
    end else begin
      res = diff[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      left      <= '0;
      center    <= '0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        left   <= center;
        center <= right;
      end
      if (adv && s1_info.started) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_info <= info;
    end
    if (adv && s1_info.started) begin
      out_pix <= res;
      out_end <= s1_info.frame_end;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    fire |-> !s1_valid || adv)
    else $error("transaction accepted over a held stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_info.started && out_valid && !out_ready |=> s1_valid)
    else $error("result dropped during output stall");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    adv && s1_info.started |=> out_valid)
    else $error("result not presented");

endmodule
